// ===== hdl/auto_gear_shift_scheduler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gear shift scheduler
// Clocked property wrappers with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef AUTO_GEAR_SHIFT_SCHEDULER_UNIT_ASSERT_SVH
`define AUTO_GEAR_SHIFT_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication
`define AGSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AGSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/agss_pkg.sv =====
// ----------------------------------------------------------------------------
// agss_pkg
// Shared types and constants of the gear shift scheduler.
// ----------------------------------------------------------------------------
package agss_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_UP_RPM      = 3'd1,
        CFG_DOWN_RPM    = 3'd2,
        CFG_SLIP_LIMIT  = 3'd3,
        CFG_CUT_TIME    = 3'd4,
        CFG_POWER_PEAK  = 3'd5,
        CFG_LIMITER     = 3'd6,
        CFG_TORQUE_PEAK = 3'd7
    } cfg_idx_t;

    // Fixed-point thresholds: fraction compares turned into integer bounds
    localparam logic [10:0] CLUTCH_UP_MIN   = 11'd1014; // clutch > 0.99
    localparam logic [10:0] CLUTCH_DN_MIN   = 11'd871;  // clutch > 0.85
    localparam logic [10:0] GAS_UP_MIN      = 11'd205;  // gas > 0.2
    localparam logic [10:0] GAS_COAST_MAX   = 11'd102;  // gas < 0.1
    localparam logic [15:0] SPEED_SLIP_MIN  = 16'd1280; // 5.0 m/s, Q8.8
    localparam logic [15:0] SPEED_COAST_MAX = 16'd512;  // 2.0 m/s, Q8.8

    localparam logic [3:0] GEAR_NEUTRAL = 4'd0;
    localparam logic [3:0] GEAR_FIRST   = 4'd1;
    localparam logic [3:0] GEAR_SECOND  = 4'd2;
    localparam logic [3:0] GEAR_THIRD   = 4'd3;

    // Reciprocals for constant division (exact over the operand ranges used)
    localparam logic [16:0] RECIP_50 = 17'd83887;   // >> 22
    localparam logic [15:0] RECIP_10 = 16'd52429;   // >> 19
    localparam logic [5:0]  ROUND_50 = 6'd49;

    typedef struct packed {
        logic [3:0]  gear;
        logic [4:0]  gear_total;
        logic [14:0] engine_rpm;
        logic [10:0] clutch;
        logic [10:0] gas;
        logic [15:0] tyre_slip;
        logic [15:0] speed;
        logic        shifting;
        logic        up_request;
        logic        down_request;
        logic [16:0] dt;
    } item_t;

    typedef struct packed {
        logic        shift_up;
        logic        shift_down;
        logic [10:0] gas_out;
        logic        cut_active;
    } result_t;

    typedef struct packed {
        logic        enable;
        logic [14:0] up_rpm;
        logic [14:0] down_rpm;
        logic [15:0] slip_limit;
        logic [19:0] cut_time;
        logic [14:0] power_peak_rpm;
        logic [14:0] limiter_rpm;
        logic [14:0] torque_peak_rpm;
    } cfg_t;

    typedef struct packed {
        logic [14:0] th_up;
        logic [15:0] th_dn;
    } thresh_t;

endpackage

// ===== hdl/auto_gear_shift_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// auto_gear_shift_scheduler_unit
// Automatic gear shift scheduler: one simulation tick in, one decision out.
// ----------------------------------------------------------------------------
// Usage:
//   Tick requests enter on item/item_valid and are taken when item_stall is
//   low. Decisions leave on result/result_valid and are taken by the receiver
//   when result_stall is low. Each request is registered in the input register,
//   evaluated by the shift rules combinationally and registered again in the
//   result register, which raises result_valid; one request is taken every
//   cycle while the receiver does not stall.
//   The throttle-cut countdown advances as each enabled, in-gear request with
//   no driver request moves into the result register, so back-to-back ticks
//   see the state left by the one before. When the receiver stalls, the result
//   register holds; a request already in the input register then waits and
//   item_stall rises, so at most two requests are in flight.
//   Registers must be written by the user through wr_en/wr_index/wr_data only
//   while no request is in flight; the block does not enforce this. A write,
//   derived thresholds included, applies to every request evaluated after its edge.
//   Reset clears all configuration registers, the countdown and both valid flags.
// ----------------------------------------------------------------------------
module auto_gear_shift_scheduler_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  agss_pkg::item_t                      item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output agss_pkg::result_t                    result,
    input  logic                                 wr_en,
    input  logic [agss_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [agss_pkg::CFG_DATA_W-1:0]      wr_data
);

    agss_pkg::cfg_t     cfg_reg;
    agss_pkg::cfg_t     cfg_next;
    agss_pkg::thresh_t  th;
    agss_pkg::item_t    item_reg;
    logic               item_valid_reg;
    agss_pkg::result_t  result_reg;
    agss_pkg::result_t  result_next;
    logic               result_valid_reg;
    logic               advance;
    logic               step;
    logic               take;

    // ---- configuration registers ----
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (agss_pkg::cfg_idx_t'(wr_index))
                agss_pkg::CFG_ENABLE:      cfg_next.enable          = wr_data[0];
                agss_pkg::CFG_UP_RPM:      cfg_next.up_rpm          = wr_data[14:0];
                agss_pkg::CFG_DOWN_RPM:    cfg_next.down_rpm        = wr_data[14:0];
                agss_pkg::CFG_SLIP_LIMIT:  cfg_next.slip_limit      = wr_data[15:0];
                agss_pkg::CFG_CUT_TIME:    cfg_next.cut_time        = wr_data[19:0];
                agss_pkg::CFG_POWER_PEAK:  cfg_next.power_peak_rpm  = wr_data[14:0];
                agss_pkg::CFG_LIMITER:     cfg_next.limiter_rpm     = wr_data[14:0];
                agss_pkg::CFG_TORQUE_PEAK: cfg_next.torque_peak_rpm = wr_data[14:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // thresholds load together with the registers
    agss_thresh u_thresh
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_next),
        .th    (th)
    );

    // ---- handshake ----
    assign advance    = !result_valid_reg || !result_stall;
    assign step       = item_valid_reg && advance;
    assign item_stall = item_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    agss_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .th     (th),
        .step   (step),
        .result (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/agss_thresh.sv =====
// ----------------------------------------------------------------------------
// agss_thresh
// Registered shift thresholds, derived from the engine registers when the
// upshift register is zero. They load from the incoming register values, so
// they change at the same edge as the registers themselves.
// ----------------------------------------------------------------------------
module agss_thresh
(
    input  logic               clk,
    input  logic               rst_n,
    input  agss_pkg::cfg_t     cfg,
    output agss_pkg::thresh_t  th
);

    logic [14:0] m;
    logic [15:0] m_round;
    logic [32:0] up_prod;
    logic [14:0] up_der;
    logic [30:0] dn_prod;
    logic [15:0] dn_der;
    logic [14:0] th_up_next;
    logic [15:0] th_dn_next;
    logic [14:0] th_up_reg;
    logic [15:0] th_dn_reg;

    // up = m - ceil(m / 50) = floor(m * 0.98)
    assign m       = (cfg.limiter_rpm >= cfg.power_peak_rpm) ? cfg.power_peak_rpm
                                                             : cfg.limiter_rpm;
    assign m_round = {1'b0, m} + {10'd0, agss_pkg::ROUND_50};
    assign up_prod = 33'(m_round) * 33'(agss_pkg::RECIP_50);
    assign up_der  = m - {4'd0, up_prod[32:22]};

    // down = t + floor(t / 10) = floor(t * 1.1)
    assign dn_prod = 31'(cfg.torque_peak_rpm) * 31'(agss_pkg::RECIP_10);
    assign dn_der  = {1'b0, cfg.torque_peak_rpm} + {4'd0, dn_prod[30:19]};

    assign th_up_next = (cfg.up_rpm == 15'd0) ? up_der : cfg.up_rpm;
    assign th_dn_next = (cfg.up_rpm == 15'd0) ? dn_der : {1'b0, cfg.down_rpm};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_up_reg <= '0;
            th_dn_reg <= '0;
        end
        else
        begin
            th_up_reg <= th_up_next;
            th_dn_reg <= th_dn_next;
        end
    end

    assign th.th_up = th_up_reg;
    assign th.th_dn = th_dn_reg;

endmodule

// ===== hdl/agss_core.sv =====
// ----------------------------------------------------------------------------
// agss_core
// Shift rules for one tick and the throttle-cut countdown register.
// ----------------------------------------------------------------------------
module agss_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  agss_pkg::item_t    item,
    input  agss_pkg::cfg_t     cfg,
    input  agss_pkg::thresh_t  th,
    input  logic               step,
    output agss_pkg::result_t  result
);

    logic [20:0] cut_rem_reg;
    logic [20:0] cut_rem_next;
    logic        active;
    logic        slipping;
    logic        gate;
    logic        room;
    logic        up_hit;
    logic [20:0] rem1;
    logic [20:0] rpm20;
    logic [20:0] dn13;
    logic        below_dn;
    logic        dn_a;
    logic        dn_b;
    logic        cut;
    logic [20:0] rem2;

    assign active   = cfg.enable && (item.gear != agss_pkg::GEAR_NEUTRAL)
                      && !item.up_request && !item.down_request;
    assign slipping = (item.tyre_slip > cfg.slip_limit)
                      && (item.speed > agss_pkg::SPEED_SLIP_MIN);
    assign gate     = !item.shifting && !slipping
                      && ((item.clutch >= agss_pkg::CLUTCH_UP_MIN)
                          || (item.gear == agss_pkg::GEAR_FIRST));
    assign room     = ({1'b0, item.gear} + 5'd1) < item.gear_total;

    assign up_hit = gate && (item.engine_rpm > th.th_up) && room
                    && (item.gas >= agss_pkg::GAS_UP_MIN) && (cut_rem_reg == 21'd0);

    // upshift reloads the countdown before the downshift rules look at it
    assign rem1  = up_hit ? {1'b0, cfg.cut_time} : cut_rem_reg;

    // gear three: rpm < floor(th_dn * 0.65) holds when 20 * (rpm + 1) <= 13 * th_dn
    assign rpm20    = ({6'd0, item.engine_rpm} << 4) + ({6'd0, item.engine_rpm} << 2)
                      + 21'd20;
    assign dn13     = ({5'd0, th.th_dn} << 3) + ({5'd0, th.th_dn} << 2)
                      + {5'd0, th.th_dn};
    assign below_dn = (item.gear == agss_pkg::GEAR_THIRD) ? (rpm20 <= dn13)
                                                          : ({1'b0, item.engine_rpm} < th.th_dn);

    assign dn_a  = gate && below_dn
                   && (item.gear > agss_pkg::GEAR_SECOND)
                   && (item.clutch >= agss_pkg::CLUTCH_DN_MIN) && (rem1 == 21'd0);
    assign dn_b  = (item.speed < agss_pkg::SPEED_COAST_MAX) && !item.shifting
                   && (item.gas <= agss_pkg::GAS_COAST_MAX) && (rem1 == 21'd0)
                   && (item.gear > agss_pkg::GEAR_SECOND);

    assign cut  = (rem1 != 21'd0);
    // saturate the countdown at zero
    assign rem2 = (rem1 > {4'd0, item.dt}) ? (rem1 - {4'd0, item.dt}) : 21'd0;

    always_comb
    begin
        if (active)
        begin
            result.shift_up   = up_hit;
            result.shift_down = dn_a || dn_b;
            result.gas_out    = cut ? 11'd0 : item.gas;
            result.cut_active = cut;
        end
        else
        begin
            result.shift_up   = item.up_request;
            result.shift_down = item.down_request;
            result.gas_out    = item.gas;
            result.cut_active = 1'b0;
        end
    end

    assign cut_rem_next = (step && active) ? rem2 : cut_rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_rem_reg <= '0;
        end
        else
        begin
            cut_rem_reg <= cut_rem_next;
        end
    end

endmodule

// ===== hdl/agss_checker.sv =====
// ----------------------------------------------------------------------------
// agss_checker
// Port-level checks of the gear shift scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "auto_gear_shift_scheduler_unit_assert.svh"

module agss_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_stall,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  agss_pkg::result_t                    result
);

    `AGSS_ASSERT_NXT(a_result_holds, clk, rst_n, result_valid && result_stall,
        result_valid, "result dropped while stalled")

    `AGSS_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, item_stall,
        result_valid && result_stall, "input stalled with result side free")

    `AGSS_ASSERT_IMP(a_cut_zero_gas, clk, rst_n, result_valid && result.cut_active,
        result.gas_out == 11'd0, "throttle not zero during cut")

    `AGSS_ASSERT_IMP(a_cut_no_down, clk, rst_n, result_valid && result.cut_active,
        !result.shift_down, "downshift issued during throttle cut")

endmodule

bind auto_gear_shift_scheduler_unit agss_checker u_agss_checker (.*);

// ===== tb/tb_auto_gear_shift_scheduler_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_auto_gear_shift_scheduler_unit
// Self-checking bench for the gear shift scheduler. Each accepted tick
// request is run through a local model of the shift rules and the throttle
// cut countdown. The resulting decision is queued and compared field by
// field with what the block returns. Directed ticks cover the rule edges.
// Random ticks follow under several register settings, with random idling
// on both channels.
// ----------------------------------------------------------------------------

class shift_scoreboard;
    agss_pkg::cfg_t    regs;
    logic [20:0]       cut_left;
    agss_pkg::result_t decisions_due[$];
    int                errors;
    int                mismatches;

    function new();
        regs = '0;
        cut_left = '0;
        errors = 0;
        mismatches = 0;
    endfunction

    function void write_reg(agss_pkg::cfg_idx_t idx, logic [19:0] val);
        case (idx)
            agss_pkg::CFG_ENABLE:      regs.enable = val[0];
            agss_pkg::CFG_UP_RPM:      regs.up_rpm = val[14:0];
            agss_pkg::CFG_DOWN_RPM:    regs.down_rpm = val[14:0];
            agss_pkg::CFG_SLIP_LIMIT:  regs.slip_limit = val[15:0];
            agss_pkg::CFG_CUT_TIME:    regs.cut_time = val;
            agss_pkg::CFG_POWER_PEAK:  regs.power_peak_rpm = val[14:0];
            agss_pkg::CFG_LIMITER:     regs.limiter_rpm = val[14:0];
            agss_pkg::CFG_TORQUE_PEAK: regs.torque_peak_rpm = val[14:0];
            default: ;
        endcase
    endfunction

    // zero up threshold means: derive both from the engine curve
    function int unsigned up_threshold();
        int unsigned lo;
        if (regs.up_rpm != 0)
            return 32'(regs.up_rpm);
        lo = 32'((regs.limiter_rpm >= regs.power_peak_rpm) ? regs.power_peak_rpm
                                                            : regs.limiter_rpm);
        return lo * 98 / 100;
    endfunction

    function int unsigned down_threshold();
        if (regs.up_rpm != 0)
            return 32'(regs.down_rpm);
        return 32'(regs.torque_peak_rpm) * 11 / 10;
    endfunction

    function agss_pkg::result_t shift_decision(agss_pkg::item_t t);
        agss_pkg::result_t d;
        int unsigned       th_up, th_dn, dn_th, rem;
        int unsigned       rpm, clutch, gas, dt;
        bit                slipping;
        d.shift_up = t.up_request;
        d.shift_down = t.down_request;
        d.gas_out = t.gas;
        d.cut_active = 1'b0;
        rpm = 32'(t.engine_rpm);
        clutch = 32'(t.clutch);
        gas = 32'(t.gas);
        dt = 32'(t.dt);
        if (regs.enable && t.gear != agss_pkg::GEAR_NEUTRAL && !t.up_request
            && !t.down_request)
        begin
            th_up = up_threshold();
            th_dn = down_threshold();
            rem = 32'(cut_left);
            slipping = (t.tyre_slip > regs.slip_limit) && (t.speed > 16'd1280);
            // clutch above 0.99, or first gear, and traction held
            if (!t.shifting && (clutch * 100 > 99 * 1024 || t.gear == agss_pkg::GEAR_FIRST)
                && !slipping)
            begin
                if (rpm > th_up && int'(t.gear) < int'(t.gear_total) - 1
                    && gas * 10 > 2048 && rem == 0)
                begin
                    d.shift_up = 1'b1;
                    rem = 32'(regs.cut_time);
                end
                dn_th = (t.gear == agss_pkg::GEAR_THIRD) ? th_dn * 65 / 100 : th_dn;
                if (rpm < dn_th && t.gear > agss_pkg::GEAR_SECOND && clutch * 100 > 85 * 1024
                    && rem == 0)
                    d.shift_down = 1'b1;
            end
            // coasting: slow, throttle closed
            if (t.speed < 16'd512 && !t.shifting && gas * 10 < 1024 && rem == 0
                && t.gear > agss_pkg::GEAR_SECOND)
                d.shift_down = 1'b1;
            if (rem > 0)
            begin
                rem = (rem > dt) ? rem - dt : 0;
                d.gas_out = '0;
                d.cut_active = 1'b1;
            end
            cut_left = rem[20:0];
        end
        return d;
    endfunction

    function void note_tick(agss_pkg::item_t t);
        decisions_due.push_back(shift_decision(t));
    endfunction

    function void check_decision(agss_pkg::result_t got);
        agss_pkg::result_t want;
        if (decisions_due.size() == 0)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected decision: up=%0d dn=%0d gas=%0d cut=%0d",
                         got.shift_up, got.shift_down, got.gas_out, got.cut_active);
            return;
        end
        want = decisions_due.pop_front();
        if (got !== want)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("decision mismatch: expected up=%0d dn=%0d gas=%0d cut=%0d",
                         want.shift_up, want.shift_down, want.gas_out, want.cut_active);
                $display("  got up=%0d dn=%0d gas=%0d cut=%0d",
                         got.shift_up, got.shift_down, got.gas_out, got.cut_active);
            end
        end
    endfunction
endclass

module tb_auto_gear_shift_scheduler_unit;

    localparam int LIMIT_CYCLES = 500000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            item_valid = 1'b0;
    logic                            item_stall;
    agss_pkg::item_t                 item = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    agss_pkg::result_t               result;
    logic                            wr_en = 1'b0;
    logic [agss_pkg::CFG_IDX_W-1:0]  wr_index = agss_pkg::CFG_ENABLE;
    logic [agss_pkg::CFG_DATA_W-1:0] wr_data = '0;

    shift_scoreboard sb = new();
    bit              calm = 1'b0;
    int              cycle_count = 0;

    auto_gear_shift_scheduler_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_auto_gear_shift_scheduler_unit: FAIL");
            $finish;
        end
    end

    // receiver: take decisions, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_decision(result);
            result_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);
        end
    end

    task automatic write_reg(input agss_pkg::cfg_idx_t idx, input logic [19:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(input agss_pkg::cfg_t c);
        write_reg(agss_pkg::CFG_ENABLE, 20'(c.enable));
        write_reg(agss_pkg::CFG_UP_RPM, 20'(c.up_rpm));
        write_reg(agss_pkg::CFG_DOWN_RPM, 20'(c.down_rpm));
        write_reg(agss_pkg::CFG_SLIP_LIMIT, 20'(c.slip_limit));
        write_reg(agss_pkg::CFG_CUT_TIME, c.cut_time);
        write_reg(agss_pkg::CFG_POWER_PEAK, 20'(c.power_peak_rpm));
        write_reg(agss_pkg::CFG_LIMITER, 20'(c.limiter_rpm));
        write_reg(agss_pkg::CFG_TORQUE_PEAK, 20'(c.torque_peak_rpm));
        @(posedge clk);
        wr_en <= 1'b0;
        // leave a short gap before the next request
        repeat (4) @(posedge clk);
    endtask

    function automatic agss_pkg::cfg_t make_setting(int unsigned en, int unsigned up,
                                                    int unsigned dn, int unsigned slip,
                                                    int unsigned cut, int unsigned pp,
                                                    int unsigned lim, int unsigned tq);
        agss_pkg::cfg_t c;
        c.enable = en[0];
        c.up_rpm = up[14:0];
        c.down_rpm = dn[14:0];
        c.slip_limit = slip[15:0];
        c.cut_time = cut[19:0];
        c.power_peak_rpm = pp[14:0];
        c.limiter_rpm = lim[14:0];
        c.torque_peak_rpm = tq[14:0];
        return c;
    endfunction

    // hold the sender until every decision is back, then let the pipe empty
    task automatic drain();
        item_valid <= 1'b0;
        while (sb.decisions_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tick(input agss_pkg::item_t t);
        if (!calm && $urandom_range(0, 99) < 23)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 40);
        end
        item_valid <= 1'b1;
        item <= t;
        do @(posedge clk); while (item_stall);
        sb.note_tick(t);
    endtask

    function automatic agss_pkg::item_t nominal_tick();
        agss_pkg::item_t t;
        t.gear = 4'd4;
        t.gear_total = 5'd6;
        t.engine_rpm = 15'd4000;
        t.clutch = 11'd1024;
        t.gas = 11'd512;
        t.tyre_slip = 16'd0;
        t.speed = 16'd5000;
        t.shifting = 1'b0;
        t.up_request = 1'b0;
        t.down_request = 1'b0;
        t.dt = 17'd10000;
        return t;
    endfunction

    function automatic int unsigned near(int th);
        int v;
        v = th + int'($urandom_range(0, 800)) - 400;
        if (v < 0)
            v = 0;
        if (v > 32767)
            v = 32767;
        return unsigned'(v);
    endfunction

    function automatic agss_pkg::item_t random_tick();
        agss_pkg::item_t t;
        int unsigned     p;
        logic [127:0]    noise;
        if ($urandom_range(0, 99) < 10)
        begin
            // noise: every field over its full width
            noise = {$urandom, $urandom, $urandom, $urandom};
            t = noise[$bits(agss_pkg::item_t)-1:0];
            return t;
        end
        t.gear = 4'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 7)
                                                 : $urandom_range(0, 15));
        t.gear_total = 5'(($urandom_range(0, 99) < 80) ? $urandom_range(5, 9)
                                                       : $urandom_range(0, 31));
        p = $urandom_range(0, 99);
        if (p < 25)
            t.engine_rpm = 15'($urandom_range(0, 20000));
        else if (p < 35)
            t.engine_rpm = 15'($urandom_range(0, 32767));
        else if (p < 65)
            t.engine_rpm = 15'(near(int'(sb.up_threshold())));
        else if (p < 85)
            t.engine_rpm = 15'(near(int'(sb.down_threshold())));
        else
            t.engine_rpm = 15'(near(int'(sb.down_threshold() * 65 / 100)));
        p = $urandom_range(0, 99);
        if (p < 65)
            t.clutch = 11'($urandom_range(1015, 1024));
        else if (p < 80)
            t.clutch = 11'($urandom_range(860, 1014));
        else
            t.clutch = 11'($urandom_range(0, 2047));
        p = $urandom_range(0, 99);
        if (p < 70)
            t.gas = 11'($urandom_range(0, 1024));
        else if (p < 80)
            t.gas = 11'($urandom_range(195, 215));
        else if (p < 90)
            t.gas = 11'($urandom_range(95, 110));
        else
            t.gas = 11'($urandom_range(0, 2047));
        t.tyre_slip = 16'(($urandom_range(0, 99) < 50) ? $urandom_range(0, 1023) : $urandom);
        p = $urandom_range(0, 99);
        if (p < 25)
            t.speed = 16'($urandom_range(0, 600));
        else if (p < 85)
            t.speed = 16'($urandom_range(0, 32767));
        else
            t.speed = 16'($urandom);
        t.shifting = ($urandom_range(0, 99) < 10);
        t.up_request = ($urandom_range(0, 99) < 8);
        t.down_request = ($urandom_range(0, 99) < 8);
        p = $urandom_range(0, 99);
        if (p < 70)
            t.dt = 17'($urandom_range(1000, 20000));
        else if (p < 85)
            t.dt = 17'($urandom_range(0, 1000));
        else
            t.dt = 17'($urandom_range(0, 131071));
        return t;
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_tick(random_tick());
    endtask

    // rule edges under up 6000, down 2500, slip 0x300, cut 50000
    task automatic directed_ticks();
        agss_pkg::item_t t;
        t = nominal_tick(); t.gear = 4'd2; t.engine_rpm = 15'd7000; send_tick(t);
        t = nominal_tick(); t.engine_rpm = 15'd7000; t.dt = 17'd20000; send_tick(t);
        t = nominal_tick(); t.dt = 17'h1FFFF; send_tick(t);
        t = nominal_tick(); t.engine_rpm = 15'd2000; t.dt = 17'd0; send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_THIRD; t.engine_rpm = 15'd2000;
        send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_THIRD; t.engine_rpm = 15'd1500;
        send_tick(t);
        t = nominal_tick(); t.speed = 16'd100; t.gas = 11'd50; t.clutch = 11'd0;
        send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_NEUTRAL; t.engine_rpm = 15'd7000;
        send_tick(t);
        t = nominal_tick(); t.up_request = 1'b1; t.gas = 11'h7FF; send_tick(t);
        t = nominal_tick(); t.down_request = 1'b1; t.engine_rpm = 15'd7000; send_tick(t);
        t = nominal_tick(); t.up_request = 1'b1; t.down_request = 1'b1; send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_FIRST; t.clutch = 11'd0;
        t.engine_rpm = 15'd7000; t.gas = 11'd1024; send_tick(t);
        t = nominal_tick(); t.dt = 17'd65535; send_tick(t);
        t = nominal_tick(); t.tyre_slip = 16'hFFFF; t.speed = 16'hFFFF;
        t.engine_rpm = 15'd7000; send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_FIRST; t.gear_total = 5'd0;
        t.engine_rpm = 15'h7FFF; send_tick(t);
        t = nominal_tick(); t.gear = 4'hF; t.gear_total = 5'h1F; t.engine_rpm = 15'h7FFF;
        t.gas = 11'h7FF; t.clutch = 11'h7FF; send_tick(t);
        t = nominal_tick(); t.dt = 17'h1FFFF; send_tick(t);
        t = nominal_tick(); t.gear = 4'd14; t.gear_total = 5'd15; t.engine_rpm = 15'd7000;
        send_tick(t);
        t = nominal_tick(); t.shifting = 1'b1; t.engine_rpm = 15'd7000; send_tick(t);
        t = nominal_tick(); t.clutch = 11'd1014; t.engine_rpm = 15'd7000; send_tick(t);
        t = nominal_tick(); t.clutch = 11'd1015; t.gas = 11'd204; t.engine_rpm = 15'd7000;
        send_tick(t);
        t = nominal_tick(); t.clutch = 11'd1015; t.gas = 11'd205; t.engine_rpm = 15'd7000;
        t.dt = 17'h1FFFF; send_tick(t);
        t = nominal_tick(); t.clutch = 11'd870; t.engine_rpm = 15'd2000; send_tick(t);
        t = nominal_tick(); t.clutch = 11'd871; t.engine_rpm = 15'd2000; send_tick(t);
        t = nominal_tick(); t.gear = agss_pkg::GEAR_THIRD; t.speed = 16'd511;
        t.gas = 11'd102; t.clutch = 11'd0; send_tick(t);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        apply_setting(make_setting(1, 6000, 2500, 'h300, 50000, 7000, 7500, 4000));
        directed_ticks();
        run_random(100);
        calm = 1'b1;
        run_random(200);
        calm = 1'b0;
        drain();

        // derived thresholds with no cut: both requests can fire together
        apply_setting(make_setting(1, 0, 1234, 'h200, 0, 6000, 5500, 5500));
        run_random(300);
        drain();

        apply_setting(make_setting(0, 5000, 3000, 'h100, 30000, 6000, 6000, 4000));
        run_random(150);
        drain();

        apply_setting(make_setting(1, 'h7FFF, 'h7FFF, 'hFFFF, 'hFFFFF, 'h7FFF, 'h7FFF,
                                   'h7FFF));
        run_random(150);
        drain();

        apply_setting(make_setting(1, 0, 0, 0, 0, 0, 0, 0));
        run_random(150);
        drain();

        for (int k = 0; k < 3; k++)
        begin
            apply_setting(make_setting(32'($urandom_range(0, 99) < 85),
                                       ($urandom_range(0, 2) == 0) ? 0
                                                                   : $urandom_range(0, 32767),
                                       $urandom_range(0, 32767), $urandom_range(0, 65535),
                                       $urandom_range(0, 200000), $urandom_range(0, 32767),
                                       $urandom_range(0, 32767), $urandom_range(0, 32767)));
            run_random(220);
            drain();
        end

        item_valid <= 1'b0;
        while (sb.decisions_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (sb.errors == 0 && sb.decisions_due.size() == 0)
            $display("tb_auto_gear_shift_scheduler_unit: PASS");
        else
            $display("tb_auto_gear_shift_scheduler_unit: FAIL");
        $finish;
    end

endmodule

// ===== auto_gear_shift_scheduler_unit.f =====
+incdir+hdl
hdl/agss_pkg.sv
hdl/agss_thresh.sv
hdl/agss_core.sv
hdl/auto_gear_shift_scheduler_unit.sv
hdl/agss_checker.sv
tb/tb_auto_gear_shift_scheduler_unit.sv
